### design/dtc_pkg.sv
// Shared types and constants for the decision tree classifier.
// Node entry layout, command codes, register map and register reset values.
// No dependencies.
package dtc_pkg;

    // Command codes carried on s_cmd
    typedef enum logic [1:0] {
        CMD_NODE     = 2'd0,
        CMD_SAMPLE   = 2'd1,
        CMD_CLASSIFY = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    // Default storage sizes
    localparam int NODE_COUNT_DEF    = 256;
    localparam int FEATURE_SLOTS_DEF = 16;

    // Field widths fixed by the interface
    localparam int NODE_IDX_W = 8;
    localparam int FEAT_SEL_W = 4;
    localparam int VALUE_W    = 32;

    // One node table entry (54 bits)
    typedef struct packed {
        logic                      leaf;
        logic [FEAT_SEL_W-1:0]     feature;
        logic signed [VALUE_W-1:0] threshold;
        logic                      cls;
        logic [NODE_IDX_W-1:0]     left;
        logic [NODE_IDX_W-1:0]     right;
    } node_entry_t;

    localparam int NODE_W = $bits(node_entry_t);

    // Configuration register map
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_LIMIT    = 1'b1;

    localparam logic [4:0] FEATURE_COUNT_RST = 5'd16;
    localparam logic [7:0] WALK_LIMIT_RST    = 8'd16;

    // Register values seen by the walk sequencer
    typedef struct packed {
        logic [4:0] feature_count;
        logic [7:0] walk_limit;
    } walk_cfg_t;

endpackage

### design/dtc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read.
// Used for the node table and the sample store. No dependencies.
module dtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/dtc_cfg.sv
// APB-style configuration registers: feature_count and walk_limit.
// Depends on dtc_pkg.
module dtc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dtc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dtc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dtc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output dtc_pkg::walk_cfg_t             cfg
);
    import dtc_pkg::*;

    logic [4:0]           feature_count_reg;
    logic [7:0]           walk_limit_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feature_count_reg <= FEATURE_COUNT_RST;
            walk_limit_reg    <= WALK_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FEATURE_COUNT: feature_count_reg <= pwdata[4:0];
                REG_WALK_LIMIT:    walk_limit_reg    <= pwdata[7:0];
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_FEATURE_COUNT: prdata = CFG_DATA_W'(feature_count_reg);
            REG_WALK_LIMIT:    prdata = CFG_DATA_W'(walk_limit_reg);
        endcase
    end

    assign cfg.feature_count = feature_count_reg;
    assign cfg.walk_limit    = walk_limit_reg;

endmodule

### design/dtc_walk.sv
// Tree walk sequencer: one shared signed comparator stepped over the nodes,
// driving the read ports of the node table and sample store, plus the result register.
// Depends on dtc_pkg.
module dtc_walk #(
    parameter int NODE_COUNT    = dtc_pkg::NODE_COUNT_DEF,
    parameter int FEATURE_SLOTS = dtc_pkg::FEATURE_SLOTS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  dtc_pkg::walk_cfg_t                     cfg,
    // input item handshake
    input  logic                                   s_valid,
    input  logic [1:0]                             s_cmd,
    output logic                                   s_ready,
    // node table read port
    output logic                                   node_re,
    output logic [$clog2(NODE_COUNT)-1:0]          node_raddr,
    input  logic [dtc_pkg::NODE_W-1:0]             node_rdata,
    // sample store read port
    output logic                                   sample_re,
    output logic [((FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1)-1:0] sample_raddr,
    input  logic signed [dtc_pkg::VALUE_W-1:0]     sample_rdata,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_pred_class,
    output logic                                   m_walk_error
);
    import dtc_pkg::*;

    localparam int NODE_AW   = $clog2(NODE_COUNT);
    localparam int SAMPLE_AW = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_CMP,
        S_RESULT
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  moves_reg, moves_next;
    logic        res_class_reg, res_class_next;
    logic        res_err_reg, res_err_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_class_reg, m_class_next;
    logic        m_err_reg, m_err_next;

    node_entry_t           node;
    logic [31:0]           feat_wide;
    logic [31:0]           child_wide;
    logic [NODE_IDX_W-1:0] child;
    logic                  below;
    logic                  feat_bad;
    logic                  child_absent;

    assign node = node_entry_t'(node_rdata);

    // Shared compare unit and child selection
    assign below        = sample_rdata < node.threshold;
    assign child        = below ? node.left : node.right;
    assign child_wide   = 32'(child);
    assign child_absent = (child == '0) || (child_wide >= 32'(NODE_COUNT));
    assign feat_wide    = 32'(node.feature);
    assign feat_bad     = (5'(node.feature) >= cfg.feature_count)
                       || (feat_wide >= 32'(FEATURE_SLOTS));

    assign node_raddr   = (state_reg == S_CMP) ? child_wide[NODE_AW-1:0] : '0;
    assign sample_raddr = feat_wide[SAMPLE_AW-1:0];

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_pred_class = m_class_reg;
    assign m_walk_error = m_err_reg;

    // Sequencer next state
    always_comb begin
        state_next     = state_reg;
        moves_next     = moves_reg;
        res_class_next = res_class_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_class_next   = m_class_reg;
        m_err_next     = m_err_reg;
        node_re        = 1'b0;
        sample_re      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // loads are written by the top level; a classify fetches the root
                if (s_valid && (s_cmd == CMD_CLASSIFY)) begin
                    node_re    = 1'b1;
                    moves_next = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                res_class_next = node.cls;
                if (node.leaf) begin
                    res_err_next = 1'b0;
                    state_next   = S_RESULT;
                end else if (feat_bad) begin
                    res_err_next = 1'b1;
                    state_next   = S_RESULT;
                end else begin
                    sample_re  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (child_absent) begin
                    res_err_next = 1'b0;
                    state_next   = S_RESULT;
                end else if (moves_reg >= cfg.walk_limit) begin
                    res_err_next = 1'b1;
                    state_next   = S_RESULT;
                end else begin
                    moves_next = moves_reg + 8'd1;
                    node_re    = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_RESULT: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_class_next = res_class_reg;
                    m_err_next   = res_err_reg;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        moves_reg     <= moves_next;
        res_class_reg <= res_class_next;
        res_err_reg   <= res_err_next;
        m_class_reg   <= m_class_next;
        m_err_reg     <= m_err_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### design/decision_tree_classify.sv
// Top level of the decision tree classifier: node table and sample store RAMs,
// configuration registers and the walk sequencer.
// Depends on dtc_pkg, dtc_ram, dtc_cfg and dtc_walk.
//
// Usage:
//   Input items arrive on the s_ valid/ready channel. cmd 0 writes one node
//   table entry, cmd 1 writes one sample feature slot, cmd 2 classifies the
//   stored sample, cmd 3 does nothing. Only a classify item produces a result
//   item on the m_ channel (class, walk_error).
//   s_ready stays high across load items. A classify holds s_ready low
//   while it walks. The node table and sample store each have one
//   registered read port, so each internal node is handled as a node read,
//   then a feature read and compare. A walk stops at a leaf, a bad feature
//   or an absent child; the default walk limit is 16 moves (255 at most).
//   The result sits in an output register; load items are still accepted
//   while it waits for m_ready. A following classify waits in its final
//   step until the output register is free.
//   Reset (aresetn low, synchronous) clears the sequencer and m_valid and
//   sets feature_count and walk_limit to 16. Node and sample contents are not
//   cleared and must be written before they are used.
//   Configuration goes through the APB-style port while the block is idle;
//   the user must keep to this, the block itself does not enforce it.
module decision_tree_classify #(
    parameter int NODE_COUNT    = dtc_pkg::NODE_COUNT_DEF,
    parameter int FEATURE_SLOTS = dtc_pkg::FEATURE_SLOTS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dtc_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [dtc_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [dtc_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_cmd,
    input  logic [dtc_pkg::NODE_IDX_W-1:0]         s_node_index,
    input  logic                                   s_leaf_flag,
    input  logic [dtc_pkg::FEAT_SEL_W-1:0]         s_feature_sel,
    input  logic signed [dtc_pkg::VALUE_W-1:0]     s_split_value,
    input  logic                                   s_node_class,
    input  logic [dtc_pkg::NODE_IDX_W-1:0]         s_left_index,
    input  logic [dtc_pkg::NODE_IDX_W-1:0]         s_right_index,
    input  logic signed [dtc_pkg::VALUE_W-1:0]     s_feature_value,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_pred_class,
    output logic                                   m_walk_error
);
    import dtc_pkg::*;

    localparam int NODE_AW   = $clog2(NODE_COUNT);
    localparam int SAMPLE_AW = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;

    walk_cfg_t             cfg;
    logic                  accept;
    logic [31:0]           node_idx_wide;
    logic [31:0]           slot_wide;
    logic                  node_we;
    logic                  sample_we;
    node_entry_t           node_wdata;
    logic                  node_re;
    logic [NODE_AW-1:0]    node_raddr;
    logic [NODE_W-1:0]     node_rdata;
    logic                  sample_re;
    logic [SAMPLE_AW-1:0]  sample_raddr;
    logic [VALUE_W-1:0]    sample_rdata;

    // Load item decode
    assign accept        = s_valid && s_ready;
    assign node_idx_wide = 32'(s_node_index);
    assign slot_wide     = 32'(s_feature_sel);
    assign node_we       = accept && (s_cmd == CMD_NODE)
                        && (node_idx_wide < 32'(NODE_COUNT));
    assign sample_we     = accept && (s_cmd == CMD_SAMPLE)
                        && (slot_wide < 32'(FEATURE_SLOTS));

    assign node_wdata.leaf      = s_leaf_flag;
    assign node_wdata.feature   = s_feature_sel;
    assign node_wdata.threshold = s_split_value;
    assign node_wdata.cls       = s_node_class;
    assign node_wdata.left      = s_left_index;
    assign node_wdata.right     = s_right_index;

    dtc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Node table
    dtc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_idx_wide[NODE_AW-1:0]),
        .wdata (NODE_W'(node_wdata)),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Sample store
    dtc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (FEATURE_SLOTS)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (sample_we),
        .waddr (slot_wide[SAMPLE_AW-1:0]),
        .wdata (VALUE_W'(s_feature_value)),
        .re    (sample_re),
        .raddr (sample_raddr),
        .rdata (sample_rdata)
    );

    dtc_walk #(
        .NODE_COUNT    (NODE_COUNT),
        .FEATURE_SLOTS (FEATURE_SLOTS)
    ) u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_cmd        (s_cmd),
        .s_ready      (s_ready),
        .node_re      (node_re),
        .node_raddr   (node_raddr),
        .node_rdata   (node_rdata),
        .sample_re    (sample_re),
        .sample_raddr (sample_raddr),
        .sample_rdata ($signed(sample_rdata)),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pred_class (m_pred_class),
        .m_walk_error (m_walk_error)
    );

endmodule

### design/dtc_checker.sv
// Port-level checks for the decision tree classifier, bound to the top level.
// Depends on dtc_pkg and decision_tree_classify.
module dtc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_cmd,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_pred_class,
    input logic       m_walk_error
);
    import dtc_pkg::*;

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pred_class)
                                && $stable(m_walk_error))
        else $error("result changed while stalled");

    // A classify item starts a walk
    a_classify_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_CLASSIFY) |=> !s_ready)
        else $error("ready stayed high after a classify item");

    // Ready stays high after any item other than a classify
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd != CMD_CLASSIFY) |=> s_ready)
        else $error("ready dropped after a load item");

endmodule

bind decision_tree_classify dtc_checker u_dtc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_cmd        (s_cmd),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pred_class (m_pred_class),
    .m_walk_error (m_walk_error)
);
